// File: src/first_fit_extent_allocator_assert.svh
// Assertion macros for the first-fit extent allocator.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Condition in the same cycle.
`define FFEA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("first_fit_extent_allocator: same-cycle check failed");
// Condition in the following cycle.
`define FFEA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("first_fit_extent_allocator: next-cycle check failed");
`else
`define FFEA_ASSERT_IMPLY(lbl, ante, cons)
`define FFEA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/ffea_pkg.sv
// Package for the first-fit extent allocator.
// Holds default sizes, field widths and the status codes; no dependencies.
`timescale 1ns / 1ps

package ffea_pkg;

    // Default table depth and address width.
    localparam int MAX_EXTENTS_DEF = 16;
    localparam int ADDR_BITS_DEF   = 32;

    // Fixed widths of the channel fields.
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_ALLOC_FAIL = 2'd1,
        ST_FREE_FAIL  = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

endpackage

// File: src/first_fit_extent_allocator.sv
// First-fit extent allocator: sorted free-extent table with coalescing.
// Depends on ffea_pkg and first_fit_extent_allocator_assert.svh.
//
//  channel   direction  handshake           payload
//  request   in         i_valid / o_stall   i_req_type, i_region_address, i_region_size
//  result    out        o_valid / i_stall   o_granted_address, o_status
//
// One request is worked at a time; o_stall is high during reset and from
// acceptance until the result has moved into the output register. Each scanned
// extent is read and then evaluated (one read port on the extent memory, one
// shared adder). Each entry shifted up on insert is read and then written; each
// entry shifted down on remove is checked, read and then written.
// Reset empties the table at once (count to zero); there is no clearing pass.
// A stalled result holds in the output register while the next request works.
`timescale 1ns / 1ps
`include "first_fit_extent_allocator_assert.svh"

module first_fit_extent_allocator #(
    parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF,
    parameter int ADDR_BITS   = ffea_pkg::ADDR_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_req_type,
    input  logic [ffea_pkg::FIELD_W-1:0]   i_region_address,
    input  logic [ffea_pkg::FIELD_W-1:0]   i_region_size,
    // Result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ffea_pkg::FIELD_W-1:0]   o_granted_address,
    output logic [ffea_pkg::STATUS_W-1:0]  o_status
);

    localparam int AW = ADDR_BITS;
    localparam int FW = ffea_pkg::FIELD_W;
    // Working width: wide enough for any field and for one carry.
    localparam int EW = ((AW > FW) ? AW : FW) + 1;
    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_FEND, S_RD, S_EVAL, S_ASH1, S_ASH2, S_GROW, S_GDM,
        S_GURD, S_GUEV, S_INS, S_INSRD, S_INSWR, S_INSW, S_RM, S_RMRD,
        S_RMWR, S_DONE
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_k;
    logic              r_req;
    logic [FW-1:0]     r_addr;
    logic [FW-1:0]     r_size;
    logic [EW-1:0]     r_end;
    logic [EW-1:0]     r_tmp;
    logic [AW-1:0]     r_cur_start;
    logic [AW-1:0]     r_prev_start;
    logic [AW-1:0]     r_prev_len;
    logic [EW-1:0]     r_prev_end;
    logic              r_down;
    logic              r_merge;
    logic [AW-1:0]     r_res_grant;
    ffea_pkg::t_status r_res_status;
    logic              r_out_valid;
    logic [FW-1:0]     r_out_grant;
    ffea_pkg::t_status r_out_status;

    // Extent memory and its registered read data.
    logic [AW-1:0]     mem_start [MAX_EXTENTS];
    logic [AW-1:0]     mem_len   [MAX_EXTENTS];
    logic [AW-1:0]     r_rd_start;
    logic [AW-1:0]     r_rd_len;

    logic              w_accept;
    logic              w_slot_free;
    logic [EW-1:0]     w_addr_e;
    logic [EW-1:0]     w_size_e;
    logic [EW-1:0]     w_rd_start_e;
    logic [EW-1:0]     w_rd_len_e;
    logic [EW-1:0]     w_grant_e;
    logic [CW-1:0]     w_idx_p1;
    logic [CW-1:0]     w_idx_m1;
    logic [CW-1:0]     w_k_p1;
    logic [CW-1:0]     w_k_m1;
    logic              w_last;
    logic [EW-1:0]     w_add_a;
    logic [EW-1:0]     w_add_b;
    logic              w_sub;
    logic [EW-1:0]     w_sum;
    logic              w_re;
    logic [IW-1:0]     w_raddr;
    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [AW-1:0]     w_wstart;
    logic [AW-1:0]     w_wlen;

    assign w_accept     = i_valid && !o_stall;
    assign w_slot_free  = !r_out_valid || !i_stall;
    assign w_addr_e     = {{(EW-FW){1'b0}}, r_addr};
    assign w_size_e     = {{(EW-FW){1'b0}}, r_size};
    assign w_rd_start_e = {{(EW-AW){1'b0}}, r_rd_start};
    assign w_rd_len_e   = {{(EW-AW){1'b0}}, r_rd_len};
    assign w_grant_e    = {{(EW-AW){1'b0}}, r_res_grant};
    assign w_idx_p1     = r_idx + CW'(1);
    assign w_idx_m1     = r_idx - CW'(1);
    assign w_k_p1       = r_k + CW'(1);
    assign w_k_m1       = r_k - CW'(1);
    assign w_last       = (w_idx_p1 == r_count);

    // Shared adder: operand selection, memory port control per state.
    always_comb begin
        w_add_a  = '0;
        w_add_b  = '0;
        w_sub    = 1'b0;
        w_re     = 1'b0;
        w_raddr  = r_idx[IW-1:0];
        w_we     = 1'b0;
        w_waddr  = r_idx[IW-1:0];
        w_wstart = r_rd_start;
        w_wlen   = r_rd_len;
        unique case (r_state)
            S_FEND: begin
                w_add_a = w_addr_e;
                w_add_b = w_size_e;
            end
            S_RD, S_GURD: begin
                w_re = 1'b1;
            end
            S_EVAL: begin
                w_add_a = w_rd_start_e;
                w_add_b = w_rd_len_e;
            end
            S_ASH1: begin
                w_add_a = w_rd_start_e;
                w_add_b = w_size_e;
            end
            S_ASH2: begin
                w_add_a  = w_rd_len_e;
                w_add_b  = w_size_e;
                w_sub    = 1'b1;
                w_we     = 1'b1;
                w_wstart = r_tmp[AW-1:0];
                w_wlen   = w_sum[AW-1:0];
            end
            S_GROW: begin
                w_add_a  = w_rd_len_e;
                w_add_b  = w_size_e;
                w_we     = !(r_down && r_merge);
                w_wstart = r_down ? w_addr_e[AW-1:0] : r_rd_start;
                w_wlen   = w_sum[AW-1:0];
            end
            S_GDM: begin
                w_add_a  = r_tmp;
                w_add_b  = {{(EW-AW){1'b0}}, r_prev_len};
                w_we     = 1'b1;
                w_waddr  = w_idx_m1[IW-1:0];
                w_wstart = r_prev_start;
                w_wlen   = w_sum[AW-1:0];
            end
            S_GUEV: begin
                w_add_a  = r_tmp;
                w_add_b  = w_rd_len_e;
                w_we     = (w_rd_start_e == r_end);
                w_waddr  = w_idx_m1[IW-1:0];
                w_wstart = r_cur_start;
                w_wlen   = w_sum[AW-1:0];
            end
            S_INSRD: begin
                w_re    = 1'b1;
                w_raddr = w_k_m1[IW-1:0];
            end
            S_INSWR, S_RMWR: begin
                w_we    = 1'b1;
                w_waddr = r_k[IW-1:0];
            end
            S_INSW: begin
                w_we     = 1'b1;
                w_wstart = w_addr_e[AW-1:0];
                w_wlen   = w_size_e[AW-1:0];
            end
            S_RMRD: begin
                w_re    = 1'b1;
                w_raddr = w_k_p1[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    assign w_sum = w_add_a + (w_sub ? ~w_add_b : w_add_b) + {{(EW-1){1'b0}}, w_sub};

    // Extent memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_start[w_waddr] <= w_wstart;
            mem_len[w_waddr]   <= w_wlen;
        end
        if (w_re) begin
            r_rd_start <= mem_start[w_raddr];
            r_rd_len   <= mem_len[w_raddr];
        end
    end

    // Sequencer with its registered results and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The held result leaves once taken, unless a new one replaces it.
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req       <= i_req_type;
                        r_addr      <= i_region_address;
                        r_size      <= i_region_size;
                        r_idx       <= '0;
                        r_res_grant <= '0;
                        if (i_req_type) begin
                            r_state <= S_FEND;
                        end else if (r_count == '0) begin
                            r_res_status <= ffea_pkg::ST_ALLOC_FAIL;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_FEND: begin
                    r_end <= w_sum;
                    if (w_sum[EW-1:AW] != '0) begin
                        r_res_status <= ffea_pkg::ST_FREE_FAIL;
                        r_state      <= S_DONE;
                    end else if (r_count == '0) begin
                        r_state <= S_INS;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (!r_req) begin
                        // First fit: exact fit removes, larger extent shrinks.
                        if (w_rd_len_e == w_size_e) begin
                            r_res_grant  <= r_rd_start;
                            r_res_status <= ffea_pkg::ST_OK;
                            r_k          <= r_idx;
                            r_state      <= S_RM;
                        end else if (w_rd_len_e > w_size_e) begin
                            r_res_grant  <= r_rd_start;
                            r_res_status <= ffea_pkg::ST_OK;
                            r_state      <= S_ASH1;
                        end else if (w_last) begin
                            r_res_status <= ffea_pkg::ST_ALLOC_FAIL;
                            r_state      <= S_DONE;
                        end else begin
                            r_idx   <= w_idx_p1;
                            r_state <= S_RD;
                        end
                    end else begin
                        // Free: the adder gives this extent's end.
                        if (r_end < w_rd_start_e) begin
                            r_state <= S_INS;
                        end else if (r_end == w_rd_start_e) begin
                            r_down  <= 1'b1;
                            r_merge <= (r_idx != '0) && (r_prev_end == w_addr_e);
                            r_state <= S_GROW;
                        end else if (w_sum == w_addr_e) begin
                            r_down  <= 1'b0;
                            r_merge <= 1'b0;
                            r_state <= S_GROW;
                        end else if (w_last && (w_sum < r_end)) begin
                            r_idx   <= w_idx_p1;
                            r_state <= S_INS;
                        end else begin
                            r_prev_start <= r_rd_start;
                            r_prev_len   <= r_rd_len;
                            r_prev_end   <= w_sum;
                            if (w_last) begin
                                r_res_status <= ffea_pkg::ST_FREE_FAIL;
                                r_state      <= S_DONE;
                            end else begin
                                r_idx   <= w_idx_p1;
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_ASH1: begin
                    r_tmp   <= w_sum;
                    r_state <= S_ASH2;
                end
                S_ASH2: begin
                    r_state <= S_DONE;
                end
                S_GROW: begin
                    r_tmp        <= w_sum;
                    r_cur_start  <= r_rd_start;
                    r_res_status <= ffea_pkg::ST_OK;
                    if (r_down) begin
                        r_state <= r_merge ? S_GDM : S_DONE;
                    end else if (!w_last) begin
                        r_idx   <= w_idx_p1;
                        r_state <= S_GURD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_GDM: begin
                    // Merged extent now sits below; drop the upper copy.
                    r_k     <= r_idx;
                    r_state <= S_RM;
                end
                S_GURD: begin
                    r_state <= S_GUEV;
                end
                S_GUEV: begin
                    if (w_rd_start_e == r_end) begin
                        r_k     <= r_idx;
                        r_state <= S_RM;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_INS: begin
                    if (r_count == CW'(MAX_EXTENTS)) begin
                        r_res_status <= ffea_pkg::ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_k     <= r_count;
                        r_state <= (r_count == r_idx) ? S_INSW : S_INSRD;
                    end
                end
                S_INSRD: begin
                    r_state <= S_INSWR;
                end
                S_INSWR: begin
                    r_k     <= w_k_m1;
                    r_state <= (w_k_m1 == r_idx) ? S_INSW : S_INSRD;
                end
                S_INSW: begin
                    r_count      <= r_count + CW'(1);
                    r_res_status <= ffea_pkg::ST_OK;
                    r_state      <= S_DONE;
                end
                S_RM: begin
                    if (w_k_p1 == r_count) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RMRD;
                    end
                end
                S_RMRD: begin
                    r_state <= S_RMWR;
                end
                S_RMWR: begin
                    r_k     <= w_k_p1;
                    r_state <= S_RM;
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_grant  <= (r_res_status == ffea_pkg::ST_OK) ?
                                        w_grant_e[FW-1:0] : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall           = !i_rst_n || (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_granted_address = r_out_grant;
    assign o_status          = r_out_status;

    // A transfer in starts work, so the request side stalls next cycle.
    `FFEA_ASSERT_NEXT(a_busy_after_accept, w_accept, o_stall)
    // The extent count changes only while a request is being worked.
    `FFEA_ASSERT_NEXT(a_count_idle_stable, (r_state == S_IDLE) && !w_accept, $stable(r_count))
    // A table-full status is reported only with a full table.
    `FFEA_ASSERT_IMPLY(a_full_status,
        (r_state == S_DONE) && (r_res_status == ffea_pkg::ST_FULL),
        r_count == CW'(MAX_EXTENTS))
    // The count never exceeds the table depth.
    `FFEA_ASSERT_IMPLY(a_count_bound, 1'b1, r_count <= CW'(MAX_EXTENTS))

endmodule

// File: tb/ffea_tb_pkg.sv
// Request codes shared by the allocator testbench files.
// No dependencies; the block's status codes come from ffea_pkg.
`timescale 1ns / 1ps

package ffea_tb_pkg;

    // Request type carried on i_req_type.
    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_kind;

endpackage

// File: tb/ffea_extent_checker.sv
// Checker for the first-fit extent allocator: keeps its own free-extent table,
// predicts the result of every request transfer and compares result transfers.
// Depends on ffea_pkg and ffea_tb_pkg.
`timescale 1ns / 1ps

module ffea_extent_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic                          i_req_type,
    input  logic [ffea_pkg::FIELD_W-1:0]  i_region_address,
    input  logic [ffea_pkg::FIELD_W-1:0]  i_region_size,
    input  logic                          i_res_valid,
    input  logic                          i_res_stall,
    input  logic [ffea_pkg::FIELD_W-1:0]  i_granted_address,
    input  logic [ffea_pkg::STATUS_W-1:0] i_status,
    output int                            o_pending,
    output int                            o_fail_count
);
    import ffea_pkg::*;
    import ffea_tb_pkg::*;

    localparam int DEPTH = MAX_EXTENTS_DEF;

    // One outstanding reply, with the request that caused it for the log.
    typedef struct {
        t_req_kind         kind;
        logic [FIELD_W-1:0] addr;
        logic [FIELD_W-1:0] size;
        logic [FIELD_W-1:0] granted;
        t_status            status;
    } t_alloc_reply;

    // Predicted free-extent table, sorted by address.
    logic [FIELD_W-1:0] span_base [DEPTH];
    logic [FIELD_W-1:0] span_len  [DEPTH];
    int                 span_count;

    t_alloc_reply replies_due [$];

    // Prints one line per mismatch and counts it.
    task automatic log_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic void drop_span(int idx);
        if (idx >= span_count) begin
            return;
        end
        for (int k = idx; k + 1 < span_count; k++) begin
            span_base[k] = span_base[k + 1];
            span_len[k]  = span_len[k + 1];
        end
        span_count--;
    endfunction

    function automatic t_status place_span(int idx, logic [FIELD_W-1:0] base,
                                           logic [FIELD_W-1:0] len);
        if (span_count >= DEPTH) begin
            return ST_FULL;
        end
        if (idx > span_count) begin
            idx = span_count;
        end
        for (int k = span_count; k > idx; k--) begin
            span_base[k] = span_base[k - 1];
            span_len[k]  = span_len[k - 1];
        end
        span_base[idx] = base;
        span_len[idx]  = len;
        span_count++;
        return ST_OK;
    endfunction

    // First fit: an exact fit removes the extent, a larger one shrinks from below.
    function automatic t_status carve_first_fit(logic [FIELD_W-1:0] size,
                                                output logic [FIELD_W-1:0] granted);
        granted = '0;
        for (int i = 0; i < span_count; i++) begin
            if (span_len[i] == size) begin
                granted = span_base[i];
                drop_span(i);
                return ST_OK;
            end
            if (span_len[i] > size) begin
                granted      = span_base[i];
                span_base[i] = span_base[i] + size;
                span_len[i]  = span_len[i] - size;
                return ST_OK;
            end
        end
        return ST_ALLOC_FAIL;
    endfunction

    // Free: the first rule that holds for an extent in table order is applied.
    function automatic t_status return_region(logic [FIELD_W-1:0] addr,
                                              logic [FIELD_W-1:0] size);
        logic [FIELD_W:0] stop;
        logic [FIELD_W:0] lo;
        logic [FIELD_W:0] hi;
        stop = {1'b0, addr} + {1'b0, size};
        if (stop > {1'b0, {FIELD_W{1'b1}}}) begin
            return ST_FREE_FAIL;
        end
        if (span_count == 0) begin
            return place_span(0, addr, size);
        end
        for (int i = 0; i < span_count; i++) begin
            lo = {1'b0, span_base[i]};
            hi = lo + {1'b0, span_len[i]};
            if (stop < lo) begin
                return place_span(i, addr, size);
            end
            // Grow downward, then absorb the previous extent if it now touches.
            if (stop == lo) begin
                span_base[i] = addr;
                span_len[i]  = span_len[i] + size;
                if (i > 0 && {1'b0, span_base[i - 1]} + {1'b0, span_len[i - 1]} ==
                        {1'b0, addr}) begin
                    span_base[i] = span_base[i - 1];
                    span_len[i]  = span_len[i] + span_len[i - 1];
                    drop_span(i - 1);
                end
                return ST_OK;
            end
            // Grow upward, then absorb the next extent if it now touches.
            if (hi == {1'b0, addr}) begin
                span_len[i] = span_len[i] + size;
                if (i + 1 < span_count && stop == {1'b0, span_base[i + 1]}) begin
                    span_len[i] = span_len[i] + span_len[i + 1];
                    drop_span(i + 1);
                end
                return ST_OK;
            end
            if (i + 1 == span_count && hi < stop) begin
                return place_span(i + 1, addr, size);
            end
        end
        return ST_FREE_FAIL;
    endfunction

    function automatic t_alloc_reply predict_reply(logic kind, logic [FIELD_W-1:0] addr,
                                                   logic [FIELD_W-1:0] size);
        t_alloc_reply       r;
        logic [FIELD_W-1:0] g;
        r.kind = t_req_kind'(kind);
        r.addr = addr;
        r.size = size;
        g      = '0;
        if (r.kind == REQ_ALLOC) begin
            r.status = carve_first_fit(size, g);
        end else begin
            r.status = return_region(addr, size);
        end
        r.granted = (r.status == ST_OK) ? g : '0;
        return r;
    endfunction

    // Compare result transfers first, then predict the request accepted at this edge.
    always @(posedge i_clk) begin : watch
        t_alloc_reply owed;
        string        req_text;
        if (!i_rst_n) begin
            span_count = 0;
            replies_due.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (replies_due.size() == 0) begin
                    log_mismatch($sformatf("result 0x%08h status %0d with nothing outstanding",
                                           i_granted_address, i_status));
                end else begin
                    owed     = replies_due.pop_front();
                    req_text = $sformatf("%s addr 0x%08h size 0x%08h",
                                         owed.kind.name(), owed.addr, owed.size);
                    if (i_granted_address !== owed.granted) begin
                        log_mismatch($sformatf("granted_address 0x%08h, expected 0x%08h (%s)",
                                               i_granted_address, owed.granted, req_text));
                    end
                    if (i_status !== owed.status) begin
                        log_mismatch($sformatf("status %0d, expected %s (%s)",
                                               i_status, owed.status.name(), req_text));
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                replies_due.push_back(predict_reply(i_req_type, i_region_address,
                                                    i_region_size));
            end
        end
        o_pending = replies_due.size();
    end

endmodule

// File: tb/first_fit_extent_allocator_tb.sv
// Testbench top for the first-fit extent allocator: clock, reset, request and
// stall stimulus, watchdog and verdict. Depends on ffea_pkg, ffea_tb_pkg,
// ffea_extent_checker and the block itself.
`timescale 1ns / 1ps

module first_fit_extent_allocator_tb;
    import ffea_pkg::*;
    import ffea_tb_pkg::*;

    localparam int ITEM_TOTAL     = 1350;
    localparam int CALM_TAIL      = 150;
    localparam int DRAIN_EVERY    = 200;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk;
    logic               rst_n          = 1'b0;
    logic               req_valid      = 1'b0;
    logic               req_stall;
    logic               req_type       = 1'b0;
    logic [FIELD_W-1:0] region_address = '0;
    logic [FIELD_W-1:0] region_size    = '0;
    logic               res_valid;
    logic               res_stall      = 1'b0;
    logic [FIELD_W-1:0] granted_address;
    logic [STATUS_W-1:0] status;

    int items_sent   = 0;
    int gap_pct      = 25;
    bit idle_enabled = 1'b1;
    int quiet_cycles = 0;
    int pending;
    int fail_count;

    first_fit_extent_allocator DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (req_valid),
        .o_stall          (req_stall),
        .i_req_type       (req_type),
        .i_region_address (region_address),
        .i_region_size    (region_size),
        .o_valid          (res_valid),
        .i_stall          (res_stall),
        .o_granted_address(granted_address),
        .o_status         (status)
    );

    ffea_extent_checker checker_inst (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_req_valid      (req_valid),
        .i_req_stall      (req_stall),
        .i_req_type       (req_type),
        .i_region_address (region_address),
        .i_region_size    (region_size),
        .i_res_valid      (res_valid),
        .i_res_stall      (res_stall),
        .i_granted_address(granted_address),
        .i_status         (status),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Ends the run when no transfer happens on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: bursts of stall alternate with stretches of free flow.
    initial begin : result_side
        int span;
        wait (rst_n);
        forever begin
            if (idle_enabled && $urandom_range(0, 3) == 0) begin
                span = $urandom_range(1, 11);
                repeat (span) begin
                    @(negedge clk);
                    res_stall <= 1'b1;
                end
            end else begin
                span = $urandom_range(1, 16);
                repeat (span) begin
                    @(negedge clk);
                    res_stall <= 1'b0;
                end
            end
        end
    end

    // Drives one request, with an optional gap before it, and waits for its transfer.
    task automatic send_request(t_req_kind kind, logic [FIELD_W-1:0] addr,
                                logic [FIELD_W-1:0] size);
        int gap;
        gap = 0;
        if (idle_enabled && $urandom_range(1, 100) <= gap_pct) begin
            gap = $urandom_range(1, 11);
        end
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid      <= 1'b1;
        req_type       <= kind;
        region_address <= addr;
        region_size    <= size;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        items_sent++;
    endtask

    // Holds the request side idle until every outstanding result has arrived.
    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin : stimulus
        longint unsigned    unit;
        longint unsigned    window_base;
        longint unsigned    span;
        logic [FIELD_W-1:0] item_addr;
        logic [FIELD_W-1:0] item_size;
        int                 episode_len;
        int                 pick;
        int                 off;
        int                 units;
        bit                 scatter;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Empty table, address-space edge and whole-space extents.
        send_request(REQ_ALLOC, $urandom(), 32'h0);
        send_request(REQ_ALLOC, $urandom(), 32'hFFFF_FFFF);
        send_request(REQ_FREE, 32'hFFFF_FFFF, 32'h1);
        send_request(REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_FREE, 32'h0, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, $urandom(), 32'hFFFF_FFFF);
        send_request(REQ_FREE, 32'hFFFF_FFF0, 32'hF);
        send_request(REQ_ALLOC, $urandom(), 32'hF);
        // Insert, append, insert before, grow down, grow up with merges.
        send_request(REQ_FREE, 32'h1000, 32'h100);
        send_request(REQ_FREE, 32'h3000, 32'h100);
        send_request(REQ_FREE, 32'h0, 32'h10);
        send_request(REQ_FREE, 32'hF00, 32'h100);
        send_request(REQ_FREE, 32'h10, 32'hEF0);
        send_request(REQ_FREE, 32'h2000, 32'h1000);
        send_request(REQ_FREE, 32'h1100, 32'hF00);
        // Partial fit, zero-size requests and exact fits.
        send_request(REQ_ALLOC, $urandom(), 32'h10);
        send_request(REQ_ALLOC, $urandom(), 32'h0);
        send_request(REQ_FREE, 32'h8000, 32'h0);
        send_request(REQ_ALLOC, $urandom(), 32'h30F0);
        send_request(REQ_ALLOC, $urandom(), 32'h0);
        // Overlapping free that fits no rule, then no fit on a non-empty table.
        send_request(REQ_FREE, 32'h1000, 32'h100);
        send_request(REQ_FREE, 32'h1000, 32'h10);
        send_request(REQ_ALLOC, $urandom(), 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, $urandom(), 32'h100);
        drain_results();

        // Random episodes, each working inside one address window with one size unit.
        while (items_sent < ITEM_TOTAL) begin
            case ($urandom_range(0, 3))
                0:       unit = 1;
                1:       unit = 16;
                2:       unit = 4096;
                default: unit = 64'h1_0000;
            endcase
            span = 67 * unit;
            case ($urandom_range(0, 5))
                0: window_base = 0;
                1: window_base = 64'h1_0000_0000 - span;
                default: begin
                    window_base = longint'($urandom()) & ~(unit - 1);
                    if (window_base + span > 64'hFFFF_FFFF) begin
                        window_base = 64'h1_0000_0000 - span;
                    end
                end
            endcase
            episode_len = $urandom_range(10, 40);
            scatter     = ($urandom_range(0, 3) == 0);
            gap_pct     = ($urandom_range(0, 3) == 0) ? 0 : 25;

            for (int n = 0; n < episode_len && items_sent < ITEM_TOTAL; n++) begin
                idle_enabled = (items_sent < ITEM_TOTAL - CALM_TAIL);
                pick = $urandom_range(1, 100);
                if (pick <= 42) begin
                    if ($urandom_range(1, 20) == 1) begin
                        item_size = $urandom();
                    end else begin
                        item_size = 32'(unit * $urandom_range(0, 6));
                    end
                    send_request(REQ_ALLOC, $urandom(), item_size);
                end else if (pick <= 90) begin
                    // Scattered frees leave one-unit holes so the table fills up.
                    off       = scatter ? 2 * $urandom_range(0, 31) : $urandom_range(0, 63);
                    units     = scatter ? 1 : $urandom_range(0, 4);
                    item_addr = 32'(window_base + unit * off);
                    item_size = 32'(unit * units);
                    send_request(REQ_FREE, item_addr, item_size);
                end else if (pick <= 95) begin
                    send_request(t_req_kind'($urandom_range(0, 1)), $urandom(), $urandom());
                end else begin
                    // Region ending exactly at, or one past, the top of the address space.
                    item_size = $urandom_range(0, 64);
                    send_request(REQ_FREE, ~item_size + $urandom_range(0, 1), item_size);
                end
                if (items_sent % DRAIN_EVERY == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
